// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BAB_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BAB_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/bab_pkg.sv -----
// ---------------------------------------------------------------------------
// bab_pkg
// Types, constants and helpers shared by the buddy allocator modules.
// ---------------------------------------------------------------------------
package bab_pkg;

  localparam int MAX_ORDER = 10;
  localparam int BLK_W     = MAX_ORDER;
  localparam int ORD_W     = 4;
  localparam int IDX_W     = 10;
  localparam int BYTES_W   = 24;
  localparam int NEED_W    = 25;
  localparam int SHIFT_W   = 5;
  localparam int TOP_W     = 4;
  localparam int HDR_W     = 7;
  localparam int ST_W      = 2;
  localparam int PADDR_W   = 4;
  localparam int APB_DW    = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int POS_W     = (MAX_ORDER + 1 > 6) ? MAX_ORDER + 1 : 6;
  localparam int FM_AW     = POS_W - BIT_W;
  localparam int FM_DEPTH  = 1 << FM_AW;
  localparam int USED_DEPTH = 1 << BLK_W;

  localparam logic [1:0] REG_BLOCK_SHIFT  = 2'd0;
  localparam logic [1:0] REG_TOP_ORDER    = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLEAR,
    OP_ROOT,
    OP_SIZE_STEP,
    OP_SIZE_DONE,
    OP_SCAN_START,
    OP_SCAN_CHECK,
    OP_FM_READ,
    OP_FM_CLR,
    OP_FM_SET,
    OP_SPLIT_DEC,
    OP_ALLOC_MARK,
    OP_FREE_MARK,
    OP_MERGE_STEP,
    OP_LOAD_OUT
  } op_t;

  typedef enum logic [1:0] {
    TGT_SPLIT_BUDDY,
    TGT_MERGE_BUDDY,
    TGT_SELF
  } tgt_t;

  typedef struct packed {
    op_t     op;
    tgt_t    tgt;
    logic    set_code;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic reinit;
    logic clr_last;
    logic is_free;
    logic k_gt_top;
    logic size_ok;
    logic hit;
    logic scan_last;
    logic ord_eq_top;
    logic ord_eq_k;
    logic out_range;
    logic used_flag;
    logic fm_bit;
  } sts_t;

  function automatic logic [POS_W-1:0] node_pos(input logic [ORD_W-1:0] ord,
                                                input logic [BLK_W-1:0] start);
    node_pos = (POS_W'(1) << (ORD_W'(MAX_ORDER) - ord)) + POS_W'(start >> ord);
  endfunction

endpackage

// ----- hw/rtl/buddy_block_allocator.sv -----
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator: allocate by byte size, free by block index.
// ---------------------------------------------------------------------------
// One request at a time. After reset and after every top_order write the
// pool is cleared, all 2^MAX_ORDER used-table entries and the free map, and
// the root node is then marked free; s_tready stays low meanwhile. An
// allocate finds the smallest order that fits the size plus header, scans
// the free map from that order upward one 32-node word at a time, then
// splits down to the size order; a free checks the index and merges with
// free buddies, at most up to the pool order, and a rejected free goes
// straight to the result. The free map memory, with one read and one write
// port, is read one 32-bit word at a time. A finished result sits in the
// output register while the next request is taken.
module buddy_block_allocator import bab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // request_bytes[23:0], block_index[33:24]
  input  logic                 s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // granted_index[9:0], granted_order[13:10]
  output logic [ST_W-1:0]      m_tuser    // status
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  bab_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  bab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

endmodule

// ----- hw/rtl/bab_datapath.sv -----
// ---------------------------------------------------------------------------
// bab_datapath
// Config registers, free-node map, used-block table and the search,
// split and merge arithmetic, driven by commands from the controller.
// ---------------------------------------------------------------------------
module bab_datapath import bab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [ST_W-1:0]      m_tuser
);

  logic [SHIFT_W-1:0] block_shift;
  logic [TOP_W-1:0]   top_order;
  logic [HDR_W-1:0]   header_bytes;
  logic [BLK_W-1:0]   clr_cnt;

  logic               is_free;
  logic [NEED_W-1:0]  need;
  logic [BLK_W-1:0]   blk;
  logic [ORD_W-1:0]   ord;
  logic [ORD_W-1:0]   k;
  logic [FM_AW-1:0]   waddr;
  logic [BIT_W-1:0]   bitsel;
  status_t            code;
  status_t            out_code;
  logic [IDX_W-1:0]   out_idx;
  logic [ORD_W-1:0]   out_ord;

  logic [WORD_W-1:0]  fm_mem [FM_DEPTH];
  logic [WORD_W-1:0]  fm_rdata;
  logic [ORD_W:0]     used_mem [USED_DEPTH];
  logic [ORD_W:0]     u_rdata;

  logic               cfg_wr;
  logic [ORD_W-1:0]   pool_top;
  logic [POS_W-1:0]   first_pos;
  logic [POS_W-1:0]   last_pos;
  logic [POS_W-1:0]   found_pos;
  logic [POS_W-1:0]   found_off;
  logic [BLK_W-1:0]   found_start;
  logic [WORD_W-1:0]  mask;
  logic [BIT_W-1:0]   enc;
  logic [POS_W-1:0]   tgt_pos;
  logic [POS_W-1:0]   root_pos;
  logic [FM_AW-1:0]   raddr;
  logic               fm_we;
  logic [FM_AW-1:0]   fm_waddr;
  logic [WORD_W-1:0]  fm_wdata;
  logic               u_we;
  logic [BLK_W-1:0]   u_waddr;
  logic [ORD_W:0]     u_wdata;
  logic [5:0]         sumsh;
  logic [ORD_W-1:0]   used_ord;
  logic [ORD_W-1:0]   used_ord_cl;

  assign cfg_wr   = psel && penable && pwrite;
  assign pool_top = (top_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : top_order;
  assign used_ord = u_rdata[ORD_W-1:0];
  assign used_ord_cl = (used_ord > pool_top) ? pool_top : used_ord;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_BLOCK_SHIFT:  prdata = APB_DW'(block_shift);
      REG_TOP_ORDER:    prdata = APB_DW'(top_order);
      REG_HEADER_BYTES: prdata = APB_DW'(header_bytes);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    logic [POS_W-1:0] p;
    first_pos = POS_W'(1) << (ORD_W'(MAX_ORDER) - ord);
    last_pos  = first_pos + (POS_W'(1) << (pool_top - ord)) - POS_W'(1);
    for (int b = 0; b < WORD_W; b++) begin
      p = {waddr, BIT_W'(b)};
      mask[b] = fm_rdata[b] && (p >= first_pos) && (p <= last_pos);
    end
    enc = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (mask[b]) enc = BIT_W'(b);
    end
    found_pos   = {waddr, enc};
    found_off   = found_pos - first_pos;
    found_start = BLK_W'(found_off << ord);
  end

  always_comb begin
    case (cmd.tgt)
      TGT_SPLIT_BUDDY: tgt_pos = node_pos(ord, blk + (BLK_W'(1) << ord));
      TGT_MERGE_BUDDY: tgt_pos = node_pos(ord, blk ^ (BLK_W'(1) << ord));
      default:         tgt_pos = node_pos(ord, blk);
    endcase
  end

  assign root_pos = node_pos(pool_top, '0);
  assign raddr    = (cmd.op == OP_FM_READ) ? tgt_pos[POS_W-1:BIT_W] : waddr;
  assign sumsh    = 6'(block_shift) + 6'(k);

  always_comb begin
    sts.reinit     = cfg_wr && (paddr[3:2] == REG_TOP_ORDER);
    sts.clr_last   = (clr_cnt == {BLK_W{1'b1}});
    sts.is_free    = is_free;
    sts.k_gt_top   = (k > pool_top);
    sts.size_ok    = (sumsh >= 6'(NEED_W)) || ((NEED_W'(1) << sumsh) >= need);
    sts.hit        = |mask;
    sts.scan_last  = (waddr == last_pos[POS_W-1:BIT_W]);
    sts.ord_eq_top = (ord == pool_top);
    sts.ord_eq_k   = (ord == k);
    sts.out_range  = ((BLK_W+1)'(blk) >= ((BLK_W+1)'(1) << pool_top));
    sts.used_flag  = u_rdata[ORD_W];
    sts.fm_bit     = fm_rdata[bitsel];
  end

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = waddr;
    fm_wdata = fm_rdata;
    u_we     = 1'b0;
    u_waddr  = blk;
    u_wdata  = '0;
    case (cmd.op)
      OP_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_cnt[FM_AW-1:0];
        fm_wdata = '0;
        u_we     = 1'b1;
        u_waddr  = clr_cnt;
      end
      OP_ROOT: begin
        fm_we    = 1'b1;
        fm_waddr = root_pos[POS_W-1:BIT_W];
        fm_wdata = WORD_W'(1) << root_pos[BIT_W-1:0];
      end
      OP_FM_CLR, OP_MERGE_STEP: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rdata & ~(WORD_W'(1) << bitsel);
      end
      OP_FM_SET: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rdata | (WORD_W'(1) << bitsel);
      end
      OP_ALLOC_MARK: begin
        u_we    = 1'b1;
        u_wdata = {1'b1, k};
      end
      OP_FREE_MARK: begin
        u_we    = 1'b1;
        u_wdata = {1'b0, used_ord};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fm_rdata <= fm_mem[raddr];
    if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
  end

  always_ff @(posedge clk) begin
    u_rdata <= used_mem[blk];
    if (u_we) used_mem[u_waddr] <= u_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift  <= SHIFT_W'(5);
      top_order    <= TOP_W'(10);
      header_bytes <= HDR_W'(16);
      clr_cnt      <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_BLOCK_SHIFT:  block_shift  <= pwdata[SHIFT_W-1:0];
          REG_TOP_ORDER:    top_order    <= pwdata[TOP_W-1:0];
          REG_HEADER_BYTES: header_bytes <= pwdata[HDR_W-1:0];
          default: ;
        endcase
      end
      if (sts.reinit) clr_cnt <= '0;
      else if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + BLK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        is_free <= s_tuser;
        need    <= NEED_W'(s_tdata[BYTES_W-1:0]) + NEED_W'(header_bytes);
        blk     <= BLK_W'(s_tdata[BYTES_W+IDX_W-1:BYTES_W]);
        k       <= '0;
      end
      OP_SIZE_STEP:  k <= k + ORD_W'(1);
      OP_SIZE_DONE:  ord <= k;
      OP_SCAN_START: waddr <= first_pos[POS_W-1:BIT_W];
      OP_SCAN_CHECK: begin
        if (sts.hit) begin
          bitsel <= enc;
          blk    <= found_start;
        end else if (sts.scan_last) begin
          ord <= ord + ORD_W'(1);
        end else begin
          waddr <= waddr + FM_AW'(1);
        end
      end
      OP_FM_READ: begin
        waddr  <= tgt_pos[POS_W-1:BIT_W];
        bitsel <= tgt_pos[BIT_W-1:0];
      end
      OP_SPLIT_DEC: ord <= ord - ORD_W'(1);
      OP_FREE_MARK: ord <= used_ord_cl;
      OP_MERGE_STEP: begin
        blk <= blk & ~(BLK_W'(1) << ord);
        ord <= ord + ORD_W'(1);
      end
      OP_LOAD_OUT: begin
        out_code <= code;
        out_idx  <= (code == ST_OK) ? IDX_W'(blk) : '0;
        out_ord  <= (code == ST_OK) ? ord : '0;
      end
      default: ;
    endcase
    if (cmd.set_code) code <= cmd.code;
  end

  assign m_tdata = M_TDATA_W'({out_ord, out_idx});
  assign m_tuser = out_code;

endmodule

// ----- hw/rtl/bab_ctrl.sv -----
// ---------------------------------------------------------------------------
// bab_ctrl
// Sequencer for pool clearing, allocate search and split, and free merge.
// ---------------------------------------------------------------------------
module bab_ctrl import bab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_ROOT, S_IDLE, S_DECODE, S_SIZE, S_SINIT, S_SRD, S_SCHK,
    S_TAKE, S_SPLIT, S_SETRD, S_SETWR, S_FCHK, S_MCHK, S_MTST, S_PUTRD,
    S_PUTWR, S_EMIT
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.tgt      = TGT_SELF;
    cmd.set_code = 1'b0;
    cmd.code     = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op     = OP_ROOT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: state_next = sts.is_free ? S_FCHK : S_SIZE;
      S_SIZE: begin
        if (sts.k_gt_top) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_TOO_LARGE;
          state_next   = S_EMIT;
        end else if (sts.size_ok) begin
          cmd.op     = OP_SIZE_DONE;
          state_next = S_SINIT;
        end else begin
          cmd.op = OP_SIZE_STEP;
        end
      end
      S_SINIT: begin
        cmd.op     = OP_SCAN_START;
        state_next = S_SRD;
      end
      S_SRD: state_next = S_SCHK;
      S_SCHK: begin
        cmd.op = OP_SCAN_CHECK;
        if (sts.hit) begin
          state_next = S_TAKE;
        end else if (sts.scan_last) begin
          if (sts.ord_eq_top) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_NO_FREE;
            state_next   = S_EMIT;
          end else begin
            state_next = S_SINIT;
          end
        end else begin
          state_next = S_SRD;
        end
      end
      S_TAKE: begin
        cmd.op     = OP_FM_CLR;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.ord_eq_k) begin
          cmd.op       = OP_ALLOC_MARK;
          cmd.set_code = 1'b1;
          cmd.code     = ST_OK;
          state_next   = S_EMIT;
        end else begin
          cmd.op     = OP_SPLIT_DEC;
          state_next = S_SETRD;
        end
      end
      S_SETRD: begin
        cmd.op     = OP_FM_READ;
        cmd.tgt    = TGT_SPLIT_BUDDY;
        state_next = S_SETWR;
      end
      S_SETWR: begin
        cmd.op     = OP_FM_SET;
        state_next = S_SPLIT;
      end
      S_FCHK: begin
        if (sts.out_range || !sts.used_flag) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_BAD_FREE;
          state_next   = S_EMIT;
        end else begin
          cmd.op     = OP_FREE_MARK;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.ord_eq_top) begin
          state_next = S_PUTRD;
        end else begin
          cmd.op     = OP_FM_READ;
          cmd.tgt    = TGT_MERGE_BUDDY;
          state_next = S_MTST;
        end
      end
      S_MTST: begin
        if (sts.fm_bit) begin
          cmd.op     = OP_MERGE_STEP;
          state_next = S_MCHK;
        end else begin
          state_next = S_PUTRD;
        end
      end
      S_PUTRD: begin
        cmd.op     = OP_FM_READ;
        cmd.tgt    = TGT_SELF;
        state_next = S_PUTWR;
      end
      S_PUTWR: begin
        cmd.op       = OP_FM_SET;
        cmd.set_code = 1'b1;
        cmd.code     = ST_OK;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (sts.reinit) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_LOAD_OUT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/bab_checker.sv -----
// ---------------------------------------------------------------------------
// bab_checker
// Port-level checks on the allocator result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bab_checker import bab_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [ST_W-1:0]      m_tuser
);

  logic             ok;
  logic [IDX_W-1:0] idx;
  logic [ORD_W-1:0] ord;

  assign ok  = m_tvalid && (m_tuser == ST_OK);
  assign idx = m_tdata[IDX_W-1:0];
  assign ord = m_tdata[IDX_W+ORD_W-1:IDX_W];

  `BAB_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `BAB_ASSERT_IMP(a_err_zero, clk, rst, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
  `BAB_ASSERT_IMP(a_ord_max, clk, rst, ok, ord <= ORD_W'(MAX_ORDER))
  `BAB_ASSERT_IMP(a_aligned, clk, rst, ok, (idx & ((IDX_W'(1) << ord) - IDX_W'(1))) == '0)

endmodule

bind buddy_block_allocator bab_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
